@@ rtl/core/cubical_coface_enumerator_3d_top_macros.svh @@
// assertion macros shared by the coface enumerator rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CUBICAL_COFACE_ENUMERATOR_3D_TOP_MACROS_SVH
`define CUBICAL_COFACE_ENUMERATOR_3D_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CCFE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccfe check failed");

// next-cycle implication, disabled during reset
`define CCFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccfe check failed");

`endif

@@ rtl/core/ccfe_pkg.sv @@
// shared types, constants and the coface pattern table
// no dependencies; imported by every module of the coface enumerator
`timescale 1ns / 1ps
`default_nettype none

package ccfe_pkg;

  // result burst and output queue sizing
  localparam int MAX_RESULTS = 6;
  localparam int FIFO_AW     = 3;
  localparam int FIFO_DEPTH  = 1 << FIFO_AW;

  // largest padded coordinate sum before wrap: corner 31 plus offset 2
  localparam int MAX_COORD_SUM = 33;

  // cube dimension codes
  localparam logic [1:0] DIM_VERTEX = 2'd0;
  localparam logic [1:0] DIM_EDGE   = 2'd1;
  localparam logic [1:0] DIM_FACE   = 2'd2;

  // cube type that selects no pattern list
  localparam logic [1:0] TYPE_NONE = 2'd3;

  // axis code meaning no axis is decremented
  localparam logic [1:0] NO_AXIS = 2'd3;

  // input operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ENUM = 1'b1;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_CUBE_DIM   = 1'b0,
    REG_SKIP_VALUE = 1'b1
  } cfg_reg_t;

  // one neighbour offset, indexed by axis (0 = x)
  typedef logic [2:0][1:0] offset_t;

  typedef struct packed {
    logic [3:0][2:0][1:0] off;
    logic [1:0]           dec_axis;
    logic [1:0]           ctype;
  } pattern_t;

  // one result transaction
  typedef struct packed {
    logic signed [31:0] birth;
    logic [5:0]         x;
    logic [5:0]         y;
    logic [5:0]         z;
    logic [1:0]         ctype;
    logic               none_found;
    logic               last;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic       start;
    logic       load;
    logic       rd_en;
    logic [4:0] pat_idx;
    logic [1:0] nb;
    logic       first_nb;
    logic       last_nb;
    logic       fin;
  } dp_cmd_t;

  function automatic offset_t xyz(input int x, input int y, input int z);
    return {2'(z), 2'(y), 2'(x)};
  endfunction

  function automatic pattern_t mk4(input offset_t o0, input offset_t o1,
                                   input offset_t o2, input offset_t o3,
                                   input logic [1:0] dec, input logic [1:0] ty);
    pattern_t p;
    p.off      = {o3, o2, o1, o0};
    p.dec_axis = dec;
    p.ctype    = ty;
    return p;
  endfunction

  // single-voxel and two-voxel patterns repeat their offsets
  function automatic pattern_t mk1(input offset_t o, input logic [1:0] dec,
                                   input logic [1:0] ty);
    return mk4(o, o, o, o, dec, ty);
  endfunction

  function automatic pattern_t mk2(input offset_t a, input offset_t b,
                                   input logic [1:0] dec, input logic [1:0] ty);
    return mk4(a, b, a, b, dec, ty);
  endfunction

  // coface pattern table: dim 0, dim 1 by type, dim 2 by type
  function automatic pattern_t pattern_at(input logic [4:0] idx);
    pattern_t p;
    p = '0;
    case (idx)
      5'd0:  p = mk1(xyz(1, 1, 2), NO_AXIS, 2'd2);
      5'd1:  p = mk1(xyz(1, 1, 0), 2'd2, 2'd2);
      5'd2:  p = mk1(xyz(1, 2, 1), NO_AXIS, 2'd1);
      5'd3:  p = mk1(xyz(1, 0, 1), 2'd1, 2'd1);
      5'd4:  p = mk1(xyz(2, 1, 1), NO_AXIS, 2'd0);
      5'd5:  p = mk1(xyz(0, 1, 1), 2'd0, 2'd0);
      5'd6:  p = mk2(xyz(1, 1, 2), xyz(2, 1, 2), NO_AXIS, 2'd1);
      5'd7:  p = mk2(xyz(1, 1, 0), xyz(2, 1, 0), 2'd2, 2'd1);
      5'd8:  p = mk2(xyz(1, 2, 1), xyz(2, 2, 1), NO_AXIS, 2'd0);
      5'd9:  p = mk2(xyz(1, 0, 1), xyz(2, 0, 1), 2'd1, 2'd0);
      5'd10: p = mk2(xyz(1, 1, 2), xyz(1, 2, 2), NO_AXIS, 2'd2);
      5'd11: p = mk2(xyz(1, 1, 0), xyz(1, 2, 0), 2'd2, 2'd2);
      5'd12: p = mk2(xyz(2, 1, 1), xyz(2, 2, 1), NO_AXIS, 2'd0);
      5'd13: p = mk2(xyz(0, 1, 1), xyz(0, 2, 1), 2'd0, 2'd0);
      5'd14: p = mk2(xyz(1, 2, 1), xyz(1, 2, 2), NO_AXIS, 2'd2);
      5'd15: p = mk2(xyz(1, 0, 1), xyz(1, 0, 2), 2'd1, 2'd2);
      5'd16: p = mk2(xyz(2, 1, 1), xyz(2, 1, 2), NO_AXIS, 2'd1);
      5'd17: p = mk2(xyz(0, 1, 1), xyz(0, 1, 2), 2'd0, 2'd1);
      5'd18: p = mk4(xyz(1, 1, 2), xyz(2, 1, 2), xyz(1, 2, 2), xyz(2, 2, 2),
                     NO_AXIS, 2'd0);
      5'd19: p = mk4(xyz(1, 1, 0), xyz(2, 1, 0), xyz(1, 2, 0), xyz(2, 2, 0),
                     2'd2, 2'd0);
      5'd20: p = mk4(xyz(1, 2, 1), xyz(2, 2, 1), xyz(1, 2, 2), xyz(2, 2, 2),
                     NO_AXIS, 2'd0);
      5'd21: p = mk4(xyz(1, 0, 1), xyz(2, 0, 1), xyz(1, 0, 2), xyz(2, 0, 2),
                     2'd1, 2'd0);
      5'd22: p = mk4(xyz(2, 1, 1), xyz(2, 2, 1), xyz(2, 1, 2), xyz(2, 2, 2),
                     NO_AXIS, 2'd0);
      5'd23: p = mk4(xyz(0, 1, 1), xyz(0, 2, 1), xyz(0, 1, 2), xyz(0, 2, 2),
                     2'd0, 2'd0);
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ccfe_ctrl.sv @@
// sequencer: walks the coface patterns and neighbour reads of one cube
// depends on ccfe_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "cubical_coface_enumerator_3d_top_macros.svh"

module ccfe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              op,
  input  wire logic [1:0]        cube_type,
  input  wire logic [1:0]        cube_dim,
  output ccfe_pkg::dp_cmd_t      cmd,
  output logic                   busy
);
  import ccfe_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT1,
    ST_WAIT2,
    ST_FIN
  } state_t;

  state_t     state;
  logic [2:0] pat;
  logic [1:0] nb;
  logic [4:0] base;
  logic [2:0] npat;
  logic [1:0] nb_max;

  // pattern list selection
  logic       list_ok;
  logic [4:0] list_base;
  logic [2:0] list_npat;
  logic [1:0] list_nb_max;

  always_comb begin
    list_ok     = 1'b0;
    list_base   = '0;
    list_npat   = '0;
    list_nb_max = '0;
    unique case (cube_dim)
      DIM_VERTEX: begin
        list_ok     = 1'b1;
        list_npat   = 3'd6;
      end
      DIM_EDGE: begin
        list_ok     = (cube_type != TYPE_NONE);
        list_base   = 5'd6 + {1'b0, cube_type, 2'b00};
        list_npat   = 3'd4;
        list_nb_max = 2'd1;
      end
      DIM_FACE: begin
        list_ok     = (cube_type != TYPE_NONE);
        list_base   = 5'd18 + {2'b00, cube_type, 1'b0};
        list_npat   = 3'd2;
        list_nb_max = 2'd3;
      end
      default: begin
        list_ok = 1'b0;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.start    = accept && (op == OP_ENUM);
    cmd.load     = accept && (op == OP_LOAD);
    cmd.rd_en    = (state == ST_RUN);
    cmd.pat_idx  = base + {2'b00, pat};
    cmd.nb       = nb;
    cmd.first_nb = (nb == 2'd0);
    cmd.last_nb  = (nb == nb_max);
    cmd.fin      = (state == ST_FIN);
  end

  assign busy = (state != ST_IDLE);

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pat    <= '0;
      nb     <= '0;
      base   <= '0;
      npat   <= '0;
      nb_max <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (op == OP_ENUM)) begin
            pat    <= '0;
            nb     <= '0;
            base   <= list_base;
            npat   <= list_npat;
            nb_max <= list_nb_max;
            state  <= list_ok ? ST_RUN : ST_FIN;
          end
        end
        ST_RUN: begin
          if (nb == nb_max) begin
            nb <= '0;
            if (pat == npat - 3'd1) begin
              state <= ST_WAIT1;
            end else begin
              pat <= pat + 3'd1;
            end
          end else begin
            nb <= nb + 2'd1;
          end
        end
        ST_WAIT1: begin
          state <= ST_WAIT2;
        end
        ST_WAIT2: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  `CCFE_ASSERT_IMPLIES(a_no_accept_busy, clk, rst, state != ST_IDLE, !accept)
  `CCFE_ASSERT_IMPLIES(a_run_bounds, clk, rst, state == ST_RUN, (pat < npat) && (nb <= nb_max))
  `CCFE_ASSERT_NEXT(a_start_leaves_idle, clk, rst, cmd.start, (state == ST_RUN) || (state == ST_FIN))

endmodule

`default_nettype wire

@@ rtl/core/ccfe_datapath.sv @@
// datapath: voxel memory, address generation, birth maximum and result hold
// depends on ccfe_pkg; driven by ccfe_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module ccfe_datapath #(
  parameter int PADDED_SIDE = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  ccfe_pkg::dp_cmd_t          cmd,
  input  wire logic [4:0]            load_x,
  input  wire logic [4:0]            load_y,
  input  wire logic [4:0]            load_z,
  input  wire logic signed [31:0]    load_value,
  input  wire logic signed [31:0]    cube_birth,
  input  wire logic [4:0]            cube_x,
  input  wire logic [4:0]            cube_y,
  input  wire logic [4:0]            cube_z,
  input  wire logic signed [31:0]    skip_value,
  output logic                       push,
  output ccfe_pkg::result_t          push_data
);
  import ccfe_pkg::*;

  localparam int DEPTH     = PADDED_SIDE * PADDED_SIDE * PADDED_SIDE;
  localparam int AW        = $clog2(DEPTH);
  localparam int STEPS     = MAX_COORD_SUM / PADDED_SIDE;
  localparam logic [8:0] SIDE9 = 9'(PADDED_SIDE);
  localparam logic [AW-1:0] SIDE_A = AW'(PADDED_SIDE);

  // reduce a padded coordinate modulo the side by repeated subtraction
  function automatic logic [8:0] wrap(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    for (int i = 0; i < STEPS; i++) begin
      if (r >= SIDE9) begin
        r = r - SIDE9;
      end
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] grid_addr(input logic [8:0] x, input logic [8:0] y,
                                              input logic [8:0] z);
    return (AW'(x) * SIDE_A + AW'(y)) * SIDE_A + AW'(z);
  endfunction

  logic [31:0] mem [DEPTH];

  // cube held for the whole burst
  logic signed [31:0] c_birth;
  logic [2:0][4:0]    cc;

  // read stage
  logic [31:0] rdata;
  logic        s1_valid;
  logic        s1_first;
  logic        s1_last;
  logic [4:0]  s1_pat;

  // accumulate stage
  logic signed [31:0] acc;
  logic               s2_valid;
  logic [4:0]         s2_pat;

  // held result, released once a later one or the end of the burst is known
  result_t pend;
  logic    pend_valid;

  // read address from the pattern offset
  pattern_t        rd_pat;
  logic [2:0][8:0] rd_coord;
  logic [AW-1:0]   rd_addr;

  always_comb begin
    rd_pat = pattern_at(cmd.pat_idx);
    for (int a = 0; a < 3; a++) begin
      rd_coord[a] = wrap({4'b0, cc[a]} + {7'b0, rd_pat.off[cmd.nb][a]});
    end
    rd_addr = grid_addr(rd_coord[0], rd_coord[1], rd_coord[2]);
  end

  // load address and range check
  logic          ld_in_range;
  logic [AW-1:0] ld_addr;

  always_comb begin
    ld_in_range = ({4'b0, load_x} < SIDE9) && ({4'b0, load_y} < SIDE9) &&
                  ({4'b0, load_z} < SIDE9);
    ld_addr     = grid_addr({4'b0, load_x}, {4'b0, load_y}, {4'b0, load_z});
  end

  // grid write port
  always_ff @(posedge clk) begin
    if (cmd.load && ld_in_range) begin
      mem[ld_addr] <= load_value;
    end
  end

  // grid read port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // running maximum over the neighbours of one pattern
  logic signed [31:0] acc_base;
  logic signed [31:0] acc_next;

  always_comb begin
    acc_base = s1_first ? c_birth : acc;
    acc_next = ($signed(rdata) > acc_base) ? $signed(rdata) : acc_base;
  end

  // finished pattern evaluation
  pattern_t s2_rec;
  result_t  s2_res;
  logic     s2_pass;
  result_t  none_res;

  always_comb begin
    s2_rec       = pattern_at(s2_pat);
    s2_res       = '0;
    s2_res.birth = acc;
    s2_res.x     = {1'b0, cc[0]} - ((s2_rec.dec_axis == 2'd0) ? 6'd1 : 6'd0);
    s2_res.y     = {1'b0, cc[1]} - ((s2_rec.dec_axis == 2'd1) ? 6'd1 : 6'd0);
    s2_res.z     = {1'b0, cc[2]} - ((s2_rec.dec_axis == 2'd2) ? 6'd1 : 6'd0);
    s2_res.ctype = s2_rec.ctype;
    s2_pass      = (acc != skip_value);

    none_res            = '0;
    none_res.none_found = 1'b1;
    none_res.last       = 1'b1;
  end

  // queue pushes: a passed result frees the held one, the end closes the burst
  always_comb begin
    push      = 1'b0;
    push_data = pend;
    if (cmd.fin) begin
      push = 1'b1;
      if (pend_valid) begin
        push_data.last = 1'b1;
      end else begin
        push_data = none_res;
      end
    end else if (s2_valid && s2_pass && pend_valid) begin
      push = 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      c_birth <= cube_birth;
      cc      <= {cube_z, cube_y, cube_x};
    end
    if (cmd.rd_en) begin
      s1_first <= cmd.first_nb;
      s1_last  <= cmd.last_nb;
      s1_pat   <= cmd.pat_idx;
    end
    if (s1_valid) begin
      acc    <= acc_next;
      s2_pat <= s1_pat;
    end
    if (s2_valid && s2_pass) begin
      pend <= s2_res;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid && s1_last;
      if (cmd.start || cmd.fin) begin
        pend_valid <= 1'b0;
      end else if (s2_valid && s2_pass) begin
        pend_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ccfe_fifo.sv @@
// result queue between the datapath and the output channel
// depends on ccfe_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "cubical_coface_enumerator_3d_top_macros.svh"

module ccfe_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  ccfe_pkg::result_t  push_data,
  input  wire logic          pop,
  output ccfe_pkg::result_t  head,
  output logic               not_empty,
  output logic               burst_room
);
  import ccfe_pkg::*;

  result_t              entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign head       = entries[rd_ptr];
  assign not_empty  = (count != '0);
  // room for a whole burst of one cube
  assign burst_room = (count <= (FIFO_AW + 1)'(FIFO_DEPTH - MAX_RESULTS));

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // checks
  `CCFE_ASSERT_IMPLIES(a_no_overflow, clk, rst, count == (FIFO_AW + 1)'(FIFO_DEPTH), !push)
  `CCFE_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, count != '0)
  `CCFE_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

@@ rtl/core/cubical_coface_enumerator_3d_top.sv @@
// Coface enumerator for a padded 3-D voxel grid, top level.
// Input channel (in_valid / in_stall): op 0 writes one voxel of the padded grid,
// op 1 names a cube whose cofaces are enumerated. Output channel
// (out_valid / out_stall): one transaction per coface that is not skipped, in
// pattern order, last set on the final one; a cube without a passing coface
// gives a single none_found transaction with zero fields.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 cube_dim,
// index 1 skip_value; write only while the block is idle.
// A load does not hold the input; a cube holds it while the sequencer makes its
// neighbour reads through the single grid read port (6 for dimension 0, 8 for
// dimensions 1 and 2), then passes two wait states and a final state; a cube
// with an empty pattern list goes straight to the final state and queues its
// none_found transaction in the cycle after the accept. A result is queued once
// the next passing coface is known; the last one is queued in the final state.
// Results wait in an 8-deep queue; while the receiver stalls the queue fills and
// a new transaction is held off until room for a full burst remains.
// Reset (rst, synchronous) empties the queue, returns the sequencer to idle and
// sets cube_dim to 0 and skip_value to the largest positive value; the grid
// keeps no reset state and every voxel must be loaded before it is read.
`timescale 1ns / 1ps
`default_nettype none

module cubical_coface_enumerator_3d_top #(
  parameter int PADDED_SIDE = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               op,
  input  wire logic [4:0]         load_x,
  input  wire logic [4:0]         load_y,
  input  wire logic [4:0]         load_z,
  input  wire logic signed [31:0] load_value,
  input  wire logic signed [31:0] cube_birth,
  input  wire logic [4:0]         cube_x,
  input  wire logic [4:0]         cube_y,
  input  wire logic [4:0]         cube_z,
  input  wire logic [1:0]         cube_type,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      coface_birth,
  output logic signed [5:0]       coface_x,
  output logic signed [5:0]       coface_y,
  output logic signed [5:0]       coface_z,
  output logic [1:0]              coface_type,
  output logic                    none_found,
  output logic                    last,
  // configuration channel
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import ccfe_pkg::*;

  logic [1:0]         cube_dim;
  logic signed [31:0] skip_value;

  dp_cmd_t cmd;
  logic    busy;
  logic    accept;
  logic    push;
  result_t push_data;
  result_t head;
  logic    not_empty;
  logic    burst_room;
  logic    pop;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cube_dim   <= DIM_VERTEX;
      skip_value <= 32'sh7FFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CUBE_DIM:   cube_dim   <= cfg_data[1:0];
        REG_SKIP_VALUE: skip_value <= $signed(cfg_data);
        default:        cube_dim   <= cube_dim;
      endcase
    end
  end

  // input handshake
  assign in_stall = busy || !burst_room;
  assign accept   = in_valid && !in_stall;

  // output handshake
  assign out_valid    = not_empty;
  assign pop          = not_empty && !out_stall;
  assign coface_birth = head.birth;
  assign coface_x     = $signed(head.x);
  assign coface_y     = $signed(head.y);
  assign coface_z     = $signed(head.z);
  assign coface_type  = head.ctype;
  assign none_found   = head.none_found;
  assign last         = head.last;

  ccfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .cube_type (cube_type),
    .cube_dim  (cube_dim),
    .cmd       (cmd),
    .busy      (busy)
  );

  ccfe_datapath #(
    .PADDED_SIDE (PADDED_SIDE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .load_x     (load_x),
    .load_y     (load_y),
    .load_z     (load_z),
    .load_value (load_value),
    .cube_birth (cube_birth),
    .cube_x     (cube_x),
    .cube_y     (cube_y),
    .cube_z     (cube_z),
    .skip_value (skip_value),
    .push       (push),
    .push_data  (push_data)
  );

  ccfe_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .burst_room (burst_room)
  );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for cubical_coface_enumerator_3d_top
// directed table then random phases, every coface checked against a local predictor
// depends on ccfe_pkg and the rtl of the coface enumerator
`timescale 1ns / 1ps

module testbench;
  import ccfe_pkg::*;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;
  localparam logic [1:0] DIM_UNUSED = 2'd3;
  localparam int N_PLAN = 26;
  localparam int N_PHASES = 8;
  localparam int RAND_ITEMS = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum {ROW_LOAD, ROW_ENUM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [4:0]  z;
    logic [31:0] val;
    logic [1:0]  ty;
    bit          none_exp;
  } plan_row_t;

  typedef struct packed {
    logic               op;
    logic [4:0]         lx;
    logic [4:0]         ly;
    logic [4:0]         lz;
    logic signed [31:0] lval;
    logic signed [31:0] birth;
    logic [4:0]         cx;
    logic [4:0]         cy;
    logic [4:0]         cz;
    logic [1:0]         ctype;
  } grid_cmd_t;

  // clock and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_LOAD;
  logic [4:0] load_x = '0;
  logic [4:0] load_y = '0;
  logic [4:0] load_z = '0;
  logic signed [31:0] load_value = '0;
  logic signed [31:0] cube_birth = '0;
  logic [4:0] cube_x = '0;
  logic [4:0] cube_y = '0;
  logic [4:0] cube_z = '0;
  logic [1:0] cube_type = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] coface_birth;
  logic signed [5:0] coface_x;
  logic signed [5:0] coface_y;
  logic signed [5:0] coface_z;
  logic [1:0] coface_type;
  logic none_found;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state: shadow grid, registers, neighbour pattern table
  logic signed [31:0] voxel_q [0:32767];
  bit loaded [0:32767];
  logic [1:0] dim_q = DIM_VERTEX;
  logic [31:0] skip_q = Q_MAX;
  bit [1:0] nb_off [24][4][3];
  bit [1:0] dec_ax [24];
  bit [1:0] face_ty [24];
  result_t pending_cofaces [$];
  result_t want;
  plan_row_t plan [N_PLAN];

  // sequencing and statistics
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int n_items = 0;
  int n_cubes = 0;
  int n_results = 0;
  int n_empty = 0;
  int n_skipped = 0;
  int n_fail = 0;
  int quiet_cycles = 0;

  cubical_coface_enumerator_3d_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .load_x(load_x), .load_y(load_y), .load_z(load_z), .load_value(load_value),
    .cube_birth(cube_birth), .cube_x(cube_x), .cube_y(cube_y), .cube_z(cube_z),
    .cube_type(cube_type),
    .out_valid(out_valid), .out_stall(out_stall), .coface_birth(coface_birth),
    .coface_x(coface_x), .coface_y(coface_y), .coface_z(coface_z),
    .coface_type(coface_type), .none_found(none_found), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // offsets given as hex digits x, y, z; two-voxel patterns repeat a, b
  function automatic void set_shape(input int idx, input int o0, o1, o2, o3,
                                    input logic [1:0] dec, input logic [1:0] ty);
    logic [47:0] packed_offs;
    int k;
    packed_offs = {12'(o3), 12'(o2), 12'(o1), 12'(o0)};
    for (k = 0; k < 4; k++) begin
      nb_off[idx][k][0] = packed_offs[12*k+8 +: 2];
      nb_off[idx][k][1] = packed_offs[12*k+4 +: 2];
      nb_off[idx][k][2] = packed_offs[12*k +: 2];
    end
    dec_ax[idx] = dec;
    face_ty[idx] = ty;
  endfunction

  // slice of the pattern table selected by dimension and cube type
  function automatic void shape_span(input logic [1:0] dim, input logic [1:0] ty,
                                     output int first, output int cnt);
    first = 0;
    cnt = 0;
    if (dim == DIM_VERTEX) begin
      cnt = 6;
    end else if (dim == DIM_EDGE && ty != TYPE_NONE) begin
      first = 6 + 4 * ty;
      cnt = 4;
    end else if (dim == DIM_FACE && ty != TYPE_NONE) begin
      first = 18 + 2 * ty;
      cnt = 2;
    end
  endfunction

  // padded neighbour address, each axis wraps at the grid side
  function automatic logic [14:0] nb_addr(input logic [4:0] cx, cy, cz, input int idx, k);
    logic [4:0] ax, ay, az;
    ax = cx + nb_off[idx][k][0];
    ay = cy + nb_off[idx][k][1];
    az = cz + nb_off[idx][k][2];
    return {ax, ay, az};
  endfunction

  // expected coface burst of one cube
  function automatic void coface_burst(input grid_cmd_t c);
    int first, cnt, i, k, emitted;
    logic signed [31:0] b, v;
    result_t r;
    shape_span(dim_q, c.ctype, first, cnt);
    emitted = 0;
    for (i = first; i < first + cnt; i++) begin
      b = c.birth;
      for (k = 0; k < 4; k++) begin
        v = voxel_q[nb_addr(c.cx, c.cy, c.cz, i, k)];
        if (v > b) b = v;
      end
      if (b == skip_q) begin
        n_skipped++;
        continue;
      end
      r = '0;
      r.birth = b;
      r.x = {1'b0, c.cx} - ((dec_ax[i] == AX_X) ? 6'd1 : 6'd0);
      r.y = {1'b0, c.cy} - ((dec_ax[i] == AX_Y) ? 6'd1 : 6'd0);
      r.z = {1'b0, c.cz} - ((dec_ax[i] == AX_Z) ? 6'd1 : 6'd0);
      r.ctype = face_ty[i];
      pending_cofaces.push_back(r);
      emitted++;
    end
    if (emitted == 0) begin
      r = '0;
      r.none_found = 1'b1;
      r.last = 1'b1;
      pending_cofaces.push_back(r);
      n_empty++;
    end else begin
      pending_cofaces[pending_cofaces.size() - 1].last = 1'b1;
    end
  endfunction

  // value pool: extremes, current skip value, small fixed point, full range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return skip_q;
      3: return 32'h0;
      4, 5: return ($urandom_range(0, 15) << 16) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [4:0] pick_coord();
    return $urandom_range(0, 1) ? 5'($urandom_range(0, 5)) : 5'($urandom_range(28, 31));
  endfunction

  task automatic flag(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("tb: %s", msg);
  endtask

  // one input transaction, predicted when accepted, then optional sender idling
  task automatic issue(input grid_cmd_t c, input bit none_exp);
    result_t r;
    in_valid <= 1'b1;
    op <= c.op;
    load_x <= c.lx;
    load_y <= c.ly;
    load_z <= c.lz;
    load_value <= c.lval;
    cube_birth <= c.birth;
    cube_x <= c.cx;
    cube_y <= c.cy;
    cube_z <= c.cz;
    cube_type <= c.ctype;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (c.op == OP_LOAD) begin
      voxel_q[{c.lx, c.ly, c.lz}] = c.lval;
      loaded[{c.lx, c.ly, c.lz}] = 1'b1;
    end else begin
      n_cubes++;
      if (none_exp) begin
        r = '0;
        r.none_found = 1'b1;
        r.last = 1'b1;
        pending_cofaces.push_back(r);
      end else begin
        coface_burst(c);
      end
    end
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [4:0] x, y, z, input logic [31:0] val);
    grid_cmd_t c;
    c = '0;
    c.op = OP_LOAD;
    c.lx = x;
    c.ly = y;
    c.lz = z;
    c.lval = val;
    issue(c, 1'b0);
  endtask

  // load every neighbour the cube will read that was never written, then send it
  task automatic send_cube(input logic [31:0] birth, input logic [4:0] x, y, z,
                           input logic [1:0] ty, input bit none_exp);
    grid_cmd_t c;
    int first, cnt, i, k;
    logic [14:0] a;
    shape_span(dim_q, ty, first, cnt);
    for (i = first; i < first + cnt; i++) begin
      for (k = 0; k < 4; k++) begin
        a = nb_addr(x, y, z, i, k);
        if (!loaded[a]) send_load(a[14:10], a[9:5], a[4:0], pick_value());
      end
    end
    c = '0;
    c.op = OP_ENUM;
    c.birth = birth;
    c.cx = x;
    c.cy = y;
    c.cz = z;
    c.ctype = ty;
    issue(c, none_exp);
  endtask

  // register write once the block has gone idle
  task automatic write_reg(input cfg_reg_t sel, input logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_cofaces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == REG_CUBE_DIM) dim_q = data[1:0];
    else skip_q = data;
  endtask

  // receiver: random stalls, one long hold-off when armed
  initial begin
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_cofaces.size() == 0) begin
          flag($sformatf("unexpected result birth %h x %0d y %0d z %0d",
                         coface_birth, coface_x, coface_y, coface_z));
        end else begin
          want = pending_cofaces.pop_front();
          n_results++;
          if (want.birth !== coface_birth || want.x !== coface_x || want.y !== coface_y ||
              want.z !== coface_z || want.ctype !== coface_type ||
              want.none_found !== none_found || want.last !== last)
            flag($sformatf({"mismatch exp b=%h x=%h y=%h z=%h t=%0d nf=%b l=%b",
                            " got b=%h x=%h y=%h z=%h t=%0d nf=%b l=%b"},
                           want.birth, want.x, want.y, want.z, want.ctype,
                           want.none_found, want.last, coface_birth, coface_x,
                           coface_y, coface_z, coface_type, none_found, last));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int i, ph, base;
    logic [1:0] ty;
    logic [1:0] phase_dim [N_PHASES];
    logic [31:0] phase_skip [N_PHASES];

    set_shape(0,  'h112, 'h112, 'h112, 'h112, NO_AXIS, AX_Z);
    set_shape(1,  'h110, 'h110, 'h110, 'h110, AX_Z, AX_Z);
    set_shape(2,  'h121, 'h121, 'h121, 'h121, NO_AXIS, AX_Y);
    set_shape(3,  'h101, 'h101, 'h101, 'h101, AX_Y, AX_Y);
    set_shape(4,  'h211, 'h211, 'h211, 'h211, NO_AXIS, AX_X);
    set_shape(5,  'h011, 'h011, 'h011, 'h011, AX_X, AX_X);
    set_shape(6,  'h112, 'h212, 'h112, 'h212, NO_AXIS, AX_Y);
    set_shape(7,  'h110, 'h210, 'h110, 'h210, AX_Z, AX_Y);
    set_shape(8,  'h121, 'h221, 'h121, 'h221, NO_AXIS, AX_X);
    set_shape(9,  'h101, 'h201, 'h101, 'h201, AX_Y, AX_X);
    set_shape(10, 'h112, 'h122, 'h112, 'h122, NO_AXIS, AX_Z);
    set_shape(11, 'h110, 'h120, 'h110, 'h120, AX_Z, AX_Z);
    set_shape(12, 'h211, 'h221, 'h211, 'h221, NO_AXIS, AX_X);
    set_shape(13, 'h011, 'h021, 'h011, 'h021, AX_X, AX_X);
    set_shape(14, 'h121, 'h122, 'h121, 'h122, NO_AXIS, AX_Z);
    set_shape(15, 'h101, 'h102, 'h101, 'h102, AX_Y, AX_Z);
    set_shape(16, 'h211, 'h212, 'h211, 'h212, NO_AXIS, AX_Y);
    set_shape(17, 'h011, 'h012, 'h011, 'h012, AX_X, AX_Y);
    set_shape(18, 'h112, 'h212, 'h122, 'h222, NO_AXIS, AX_X);
    set_shape(19, 'h110, 'h210, 'h120, 'h220, AX_Z, AX_X);
    set_shape(20, 'h121, 'h221, 'h122, 'h222, NO_AXIS, AX_X);
    set_shape(21, 'h101, 'h201, 'h102, 'h202, AX_Y, AX_X);
    set_shape(22, 'h211, 'h221, 'h212, 'h222, NO_AXIS, AX_X);
    set_shape(23, 'h011, 'h021, 'h012, 'h022, AX_X, AX_X);

    // directed table: kind, register, x, y, z, value or birth, type, empty burst
    plan = '{
      '{ROW_LOAD, REG_CUBE_DIM,   5'd1,  5'd1,  5'd2,  Q_MAX, 2'd0, 1'b0},
      '{ROW_LOAD, REG_CUBE_DIM,   5'd31, 5'd31, 5'd31, Q_MIN, 2'd0, 1'b0},
      '{ROW_LOAD, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'h0, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  Q_MIN, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd30, 5'd30, 5'd29, Q_MIN, TYPE_NONE, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd31, 5'd31, 5'd31, Q_MAX, 2'd2, 1'b1},
      '{ROW_CFG,  REG_SKIP_VALUE, 5'd0,  5'd0,  5'd0,  Q_MIN, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd31, 5'd31, 5'd31, Q_MIN, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  Q_MIN, 2'd1, 1'b0},
      '{ROW_CFG,  REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'd1, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'h0, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'h0, 2'd1, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd31, 5'd31, 5'd31, 32'h0, 2'd2, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'h0, TYPE_NONE, 1'b1},
      '{ROW_CFG,  REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'd2, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  Q_MIN, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd31, 5'd31, 5'd31, Q_MIN, 2'd1, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  Q_MIN, 2'd2, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd29, 5'd29, 5'd29, 32'h0, TYPE_NONE, 1'b1},
      '{ROW_CFG,  REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'd3, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd5,  5'd9,  5'd17, Q_MAX, 2'd0, 1'b1},
      '{ROW_CFG,  REG_SKIP_VALUE, 5'd0,  5'd0,  5'd0,  32'h0, 2'd0, 1'b0},
      '{ROW_CFG,  REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'd0, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd0,  5'd0,  5'd0,  32'h0, 2'd1, 1'b0},
      '{ROW_CFG,  REG_SKIP_VALUE, 5'd0,  5'd0,  5'd0,  Q_MAX, 2'd0, 1'b0},
      '{ROW_ENUM, REG_CUBE_DIM,   5'd29, 5'd29, 5'd29, 32'h1, 2'd1, 1'b0}
    };

    phase_dim = '{DIM_VERTEX, DIM_EDGE, DIM_FACE, DIM_VERTEX,
                  DIM_UNUSED, DIM_EDGE, DIM_FACE, DIM_VERTEX};
    phase_skip = '{Q_MAX, 32'h0, Q_MIN, pick_value(),
                   Q_MAX, pick_value(), 32'h0001_0000, Q_MAX};

    // reset
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (i = 0; i < N_PLAN; i++) begin
      case (plan[i].kind)
        ROW_CFG:  write_reg(plan[i].sel, plan[i].val);
        ROW_LOAD: send_load(plan[i].x, plan[i].y, plan[i].z, plan[i].val);
        default:  send_cube(plan[i].val, plan[i].x, plan[i].y, plan[i].z, plan[i].ty,
                            plan[i].none_exp);
      endcase
    end

    // random phases, each with a register setting and one of four idling mixes
    base = n_items;
    for (ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_CUBE_DIM, {30'd0, phase_dim[ph]});
      write_reg(REG_SKIP_VALUE, phase_skip[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      // first phase: long output hold while items keep coming
      if (ph == 0) hold_armed = 1'b1;
      while (n_items < base + (ph + 1) * RAND_ITEMS / N_PHASES) begin
        if ($urandom_range(0, 9) < 3) begin
          send_load(pick_coord(), pick_coord(), pick_coord(), pick_value());
        end else begin
          ty = ($urandom_range(0, 9) == 0) ? TYPE_NONE : 2'($urandom_range(0, 2));
          send_cube(pick_value(), pick_coord(), pick_coord(), pick_coord(), ty, 1'b0);
        end
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (pending_cofaces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d input transactions, %0d cube queries, %0d results checked",
             n_items, n_cubes, n_results);
    $display("summary: %0d empty bursts, %0d cofaces skipped, dims 0-3, %0d mismatches",
             n_empty, n_skipped, n_fail);
    if (n_fail == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
